### rtl/rnm_pkg.sv
// Shared types and constants of the row noise mask block.
// Depends on nothing; every module of the block imports it.
package rnm_pkg;

   localparam int CHARGE_BITS = 28;
   localparam int COUNT_BITS  = 13;
   localparam int THR_BITS    = 16;
   localparam int CLIM_BITS   = 13;
   localparam int MLIM_BITS   = 15;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] IDX_MAX = '1;

   localparam logic signed [CHARGE_BITS-1:0] CHARGE_MAX = {1'b0, {(CHARGE_BITS-1){1'b1}}};
   localparam logic signed [CHARGE_BITS-1:0] CHARGE_MIN = {1'b1, {(CHARGE_BITS-1){1'b0}}};

   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COUNT_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEAN_LIMIT      = 2'd2;

   localparam logic signed [THR_BITS-1:0] THRESHOLD_RESET  = 16'sd10;
   localparam logic [CLIM_BITS-1:0]       COUNT_LIMIT_RESET = 13'd500;
   localparam logic [MLIM_BITS-1:0]       MEAN_LIMIT_RESET  = 15'd400;

   typedef struct packed {
      logic                          row_end;
      logic                          replay_valid;
      logic                          in_store;
      logic signed [CHARGE_BITS-1:0] charge_sum;
      logic [COUNT_BITS-1:0]         count_above;
   } row_info_type;

endpackage

### rtl/rnm_row_store.sv
// Row store of the row noise mask block: one synchronous memory holding the
// previous row, read-first with a registered read port. Depends on rnm_pkg.
module rnm_row_store
   import rnm_pkg::*;
#(
   parameter int MAX_COLS   = 4096,
   parameter int PIXEL_BITS = 16,
   parameter int ADDR_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  addr,
   input  logic [PIXEL_BITS-1:0] wr_data,
   output logic [PIXEL_BITS-1:0] rd_data
);

   logic [PIXEL_BITS-1:0] mem [MAX_COLS];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rnm_row_stats.sv
// Column counter and per-row statistics of the row noise mask block.
// Accumulates charge and count of above-threshold pixels. Depends on rnm_pkg.
module rnm_row_stats
   import rnm_pkg::*;
#(
   parameter int MAX_COLS   = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic signed [PIXEL_BITS-1:0] pixel,
   input  logic                         row_end,
   input  logic signed [THR_BITS-1:0]   threshold,
   output logic [COUNT_BITS-1:0]        column,
   output row_info_type                 info,
   output logic signed [PIXEL_BITS-1:0] first_pixel
);

   localparam int TW = (PIXEL_BITS > THR_BITS) ? PIXEL_BITS : THR_BITS;
   localparam int SW = ((PIXEL_BITS > CHARGE_BITS) ? PIXEL_BITS : CHARGE_BITS) + 1;
   localparam logic [COUNT_BITS:0] STORE_DEPTH = (COUNT_BITS+1)'(MAX_COLS);

   logic [COUNT_BITS-1:0]         col_ff, col_in;
   logic signed [CHARGE_BITS-1:0] charge_ff, charge_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [PIXEL_BITS-1:0]  first_ff, first_in;
   logic [COUNT_BITS-1:0]         prev_len_ff, prev_len_in;
   logic                          prev_present_ff, prev_present_in;

   logic                          above;
   logic signed [SW-1:0]          sum_wide;
   logic signed [CHARGE_BITS-1:0] sum_sat;
   logic signed [CHARGE_BITS-1:0] charge_next;
   logic [COUNT_BITS-1:0]         count_next;
   logic [COUNT_BITS-1:0]         col_step;

   assign above = TW'(pixel) > TW'(threshold);

   always_comb begin
      sum_wide = SW'(charge_ff) + SW'(pixel);
      if (sum_wide > SW'(CHARGE_MAX)) begin
         sum_sat = CHARGE_MAX;
      end else if (sum_wide < SW'(CHARGE_MIN)) begin
         sum_sat = CHARGE_MIN;
      end else begin
         sum_sat = sum_wide[CHARGE_BITS-1:0];
      end
      charge_next = above ? sum_sat : charge_ff;
      count_next  = (above && count_ff != IDX_MAX) ? count_ff + 1'b1 : count_ff;
      col_step    = (col_ff != IDX_MAX) ? col_ff + 1'b1 : IDX_MAX;
      first_pixel = (col_ff == '0) ? pixel : first_ff;

      info.row_end      = row_end;
      info.replay_valid = prev_present_ff && (col_ff < prev_len_ff);
      info.in_store     = {1'b0, col_ff} < STORE_DEPTH;
      info.charge_sum   = charge_next;
      info.count_above  = count_next;

      col_in          = col_ff;
      charge_in       = charge_ff;
      count_in        = count_ff;
      first_in        = first_ff;
      prev_len_in     = prev_len_ff;
      prev_present_in = prev_present_ff;
      if (fire) begin
         first_in = first_pixel;
         if (row_end) begin
            col_in          = '0;
            charge_in       = '0;
            count_in        = '0;
            prev_len_in     = col_step;
            prev_present_in = 1'b1;
         end else begin
            col_in    = col_step;
            charge_in = charge_next;
            count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         charge_ff       <= '0;
         count_ff        <= '0;
         first_ff        <= '0;
         prev_len_ff     <= '0;
         prev_present_ff <= 1'b0;
      end else begin
         col_ff          <= col_in;
         charge_ff       <= charge_in;
         count_ff        <= count_in;
         first_ff        <= first_in;
         prev_len_ff     <= prev_len_in;
         prev_present_ff <= prev_present_in;
      end
   end

   assign column = col_ff;

endmodule

### rtl/row_noise_mask.sv
// Row noise mask: each pixel beat on the req_ channel (pixel value and a
// row end flag, raster order) yields exactly one beat on the rsp_ channel.
// The response carries the pixel of the previous row at the same column,
// zeroed when that row was judged noise, with out_valid low where the
// previous row had no such column or no row has ended yet. On the beat that
// ends a row it also carries the row's above-threshold charge sum and count,
// the mask decision and the row's first pixel; otherwise those fields are
// zero. The last row is drained by sending one dummy row after it.
// An accepted request passes the row store read stage and then the output
// register, where the mask multiply and compare sit, before its response;
// one request is accepted every cycle unless the pipeline holds. When
// rsp_stall is high with a response waiting, the pipeline holds and req_stall
// rises in the same cycle. A synchronous reset empties the pipeline, clears
// the statistics and loads the register defaults; the row store needs no
// clearing. The csr_ port writes threshold, count limit and mean limit; the
// user must write it only while the block is idle, the block does not enforce it.
module row_noise_mask
   import rnm_pkg::*;
#(
   parameter int MAX_COLS   = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_value,
   input  logic                         req_row_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_out_valid,
   output logic signed [PIXEL_BITS-1:0] rsp_out_pixel,
   output logic                         rsp_out_row_end,
   output logic signed [CHARGE_BITS-1:0] rsp_row_charge_sum,
   output logic [COUNT_BITS-1:0]        rsp_row_count_above,
   output logic                         rsp_row_masked,
   output logic signed [PIXEL_BITS-1:0] rsp_row_first_pixel,
   input  logic                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_BITS-1:0]          csr_wdata
);

   localparam int ADDR_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PROD_BITS = MLIM_BITS + COUNT_BITS;

   logic signed [THR_BITS-1:0] threshold_ff;
   logic [CLIM_BITS-1:0]       count_limit_ff;
   logic [MLIM_BITS-1:0]       mean_limit_ff;

   logic                         advance;
   logic                         req_fire;
   logic [COUNT_BITS-1:0]        column;
   row_info_type                 info;
   logic signed [PIXEL_BITS-1:0] first_pixel;
   logic [PIXEL_BITS-1:0]        rd_data;

   logic                         s1_valid_ff;
   row_info_type                 s1_info_ff;
   logic signed [PIXEL_BITS-1:0] s1_first_ff;

   logic                         prev_masked_ff, prev_masked_in;
   logic [PROD_BITS-1:0]         product;
   logic                         masked_in;

   logic                          rsp_valid_ff;
   logic                          out_valid_ff, out_valid_in;
   logic signed [PIXEL_BITS-1:0]  out_pixel_ff, out_pixel_in;
   logic                          out_row_end_ff;
   logic signed [CHARGE_BITS-1:0] charge_ff, charge_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic                          masked_ff, row_masked_in;
   logic signed [PIXEL_BITS-1:0]  first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         count_limit_ff <= COUNT_LIMIT_RESET;
         mean_limit_ff  <= MEAN_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_THRESHOLD: threshold_ff   <= csr_wdata;
            CSR_COUNT_LIMIT:     count_limit_ff <= csr_wdata[CLIM_BITS-1:0];
            CSR_MEAN_LIMIT:      mean_limit_ff  <= csr_wdata[MLIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign req_fire  = req_valid && advance;

   rnm_row_stats #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_stats (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .pixel       (req_pixel_value),
      .row_end     (req_row_end),
      .threshold   (threshold_ff),
      .column      (column),
      .info        (info),
      .first_pixel (first_pixel)
   );

   rnm_row_store #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (advance),
      .wr_en   (req_fire && info.in_store),
      .addr    (column[ADDR_BITS-1:0]),
      .wr_data (req_pixel_value),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_info_ff  <= info;
         s1_first_ff <= first_pixel;
      end
   end

   always_comb begin
      product   = PROD_BITS'(mean_limit_ff) * PROD_BITS'(s1_info_ff.count_above);
      masked_in = (s1_info_ff.count_above > count_limit_ff) ||
                  ((s1_info_ff.count_above != '0) &&
                   ((CHARGE_BITS+1)'(s1_info_ff.charge_sum) >
                    $signed({1'b0, product})));

      out_valid_in = s1_info_ff.replay_valid;
      out_pixel_in = (s1_info_ff.replay_valid && s1_info_ff.in_store && !prev_masked_ff) ?
                     rd_data : '0;
      charge_in     = s1_info_ff.row_end ? s1_info_ff.charge_sum : '0;
      count_in      = s1_info_ff.row_end ? s1_info_ff.count_above : '0;
      row_masked_in = s1_info_ff.row_end && masked_in;
      first_in      = s1_info_ff.row_end ? s1_first_ff : '0;

      prev_masked_in = prev_masked_ff;
      if (advance && s1_valid_ff && s1_info_ff.row_end) begin
         prev_masked_in = masked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         prev_masked_ff <= 1'b0;
      end else begin
         prev_masked_ff <= prev_masked_in;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      if (advance) begin
         out_valid_ff   <= out_valid_in;
         out_pixel_ff   <= out_pixel_in;
         out_row_end_ff <= s1_info_ff.row_end;
         charge_ff      <= charge_in;
         count_ff       <= count_in;
         masked_ff      <= row_masked_in;
         first_ff       <= first_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_valid       = out_valid_ff;
   assign rsp_out_pixel       = out_pixel_ff;
   assign rsp_out_row_end     = out_row_end_ff;
   assign rsp_row_charge_sum  = charge_ff;
   assign rsp_row_count_above = count_ff;
   assign rsp_row_masked      = masked_ff;
   assign rsp_row_first_pixel = first_ff;

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("Response beat present right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff |=> rsp_valid_ff)
      else $error("Beat lost between row store stage and output register.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && masked_ff |-> out_row_end_ff && count_ff != '0)
      else $error("Mask flagged without a row end or without counted pixels.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_valid_ff |-> out_pixel_ff == '0)
      else $error("Replayed pixel nonzero where the previous row has no column.");

endmodule

### dv/tb_row_noise_mask.sv
// Self-checking testbench for row_noise_mask: drives pixel beats with random gaps and
// stalls, predicts every response beat in a cycle-free model and checks each field.
// Depends on rnm_pkg and row_noise_mask from the rtl folder.
module tb_row_noise_mask;
   import rnm_pkg::*;

   localparam int MAX_COLS   = 4096;
   localparam int PIXEL_BITS = 16;
   localparam int LINE_BITS  = $clog2(MAX_COLS);
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic                          out_valid;
      logic signed [PIXEL_BITS-1:0]  out_pixel;
      logic                          out_row_end;
      logic signed [CHARGE_BITS-1:0] charge_sum;
      logic [COUNT_BITS-1:0]         count_above;
      logic                          masked;
      logic signed [PIXEL_BITS-1:0]  first_pixel;
   } row_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [PIXEL_BITS-1:0]  req_pixel_value = '0;
   logic                          req_row_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_out_valid;
   logic signed [PIXEL_BITS-1:0]  rsp_out_pixel;
   logic                          rsp_out_row_end;
   logic signed [CHARGE_BITS-1:0] rsp_row_charge_sum;
   logic [COUNT_BITS-1:0]         rsp_row_count_above;
   logic                          rsp_row_masked;
   logic signed [PIXEL_BITS-1:0]  rsp_row_first_pixel;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index = CSR_PIXEL_THRESHOLD;
   logic [CSR_BITS-1:0]           csr_wdata = '0;

   row_beat_type due_beats[$];
   row_beat_type beat_due;
   int        failures = 0;
   int        idle_cycles = 0;
   int        stall_left = 0;
   bit        send_calm = 0;
   bit        recv_calm = 0;

   logic signed [PIXEL_BITS-1:0]  line_mem [MAX_COLS];
   logic [COUNT_BITS-1:0]         col_idx;
   logic signed [CHARGE_BITS-1:0] charge_acc;
   logic [COUNT_BITS-1:0]         count_acc;
   logic signed [PIXEL_BITS-1:0]  first_pix;
   logic [COUNT_BITS-1:0]         prev_len;
   logic                          prev_masked;
   logic                          prev_seen;
   logic signed [THR_BITS-1:0]    cfg_threshold;
   logic [CLIM_BITS-1:0]          cfg_count_limit;
   logic [MLIM_BITS-1:0]          cfg_mean_limit;

   row_noise_mask #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_value     (req_pixel_value),
      .req_row_end         (req_row_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_out_pixel       (rsp_out_pixel),
      .rsp_out_row_end     (rsp_out_row_end),
      .rsp_row_charge_sum  (rsp_row_charge_sum),
      .rsp_row_count_above (rsp_row_count_above),
      .rsp_row_masked      (rsp_row_masked),
      .rsp_row_first_pixel (rsp_row_first_pixel),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic clear_row_state();
      col_idx         = '0;
      charge_acc      = '0;
      count_acc       = '0;
      first_pix       = '0;
      prev_len        = '0;
      prev_masked     = 1'b0;
      prev_seen       = 1'b0;
      cfg_threshold   = THRESHOLD_RESET;
      cfg_count_limit = COUNT_LIMIT_RESET;
      cfg_mean_limit  = MEAN_LIMIT_RESET;
   endtask

   function automatic row_beat_type row_mask_step(input logic signed [PIXEL_BITS-1:0] pix,
                                                  input logic last);
      row_beat_type          beat;
      logic [COUNT_BITS-1:0] col;
      longint                acc;
      beat = '0;
      col  = col_idx;
      beat.out_valid = prev_seen && (col < prev_len);
      if (beat.out_valid && col < MAX_COLS && !prev_masked) begin
         beat.out_pixel = line_mem[col[LINE_BITS-1:0]];
      end
      if (col < MAX_COLS) begin
         line_mem[col[LINE_BITS-1:0]] = pix;
      end
      if (col == '0) begin
         first_pix = pix;
      end
      if (pix > cfg_threshold) begin
         acc = longint'(charge_acc) + longint'(pix);
         if (acc > longint'(CHARGE_MAX)) begin
            acc = longint'(CHARGE_MAX);
         end
         if (acc < longint'(CHARGE_MIN)) begin
            acc = longint'(CHARGE_MIN);
         end
         charge_acc = CHARGE_BITS'(acc);
         if (count_acc != IDX_MAX) begin
            count_acc = count_acc + 1'b1;
         end
      end
      if (last) begin
         beat.out_row_end = 1'b1;
         beat.charge_sum  = charge_acc;
         beat.count_above = count_acc;
         beat.first_pixel = first_pix;
         beat.masked = (count_acc > cfg_count_limit) ||
            (count_acc != '0 &&
             longint'(charge_acc) > longint'(cfg_mean_limit) * longint'(count_acc));
         prev_len    = (col != IDX_MAX) ? col + 1'b1 : IDX_MAX;
         prev_masked = beat.masked;
         prev_seen   = 1'b1;
         charge_acc  = '0;
         count_acc   = '0;
         col_idx     = '0;
      end else begin
         col_idx = (col != IDX_MAX) ? col + 1'b1 : IDX_MAX;
      end
      return beat;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [PIXEL_BITS-1:0] make_pixel(input int style);
      int v;
      case (style)
         0: begin
            v = int'($urandom_range(0, 65535)) - 32768;
         end
         1: begin
            v = int'(cfg_threshold) + int'($urandom_range(0, 1500));
         end
         2: begin
            v = int'(cfg_threshold) + int'($urandom_range(0, 80)) - 40;
         end
         default: begin
            v = $urandom_range(0, 1) ? 32767 : -32768;
         end
      endcase
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return PIXEL_BITS'(v);
   endfunction

   task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] pix, input logic last);
      int gap;
      bit taken;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_row_end     <= last;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         if (!req_stall) begin
            taken = 1;
            due_beats.push_back(row_mask_step(pix, last));
         end
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (due_beats.size() != 0);
   endtask

   task automatic set_limits(input logic signed [THR_BITS-1:0] thr,
                             input logic [CLIM_BITS-1:0] clim,
                             input logic [MLIM_BITS-1:0] mlim);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PIXEL_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      cfg_threshold = thr;
      csr_index <= CSR_COUNT_LIMIT;
      csr_wdata <= {3'b000, clim};
      @(posedge clock);
      cfg_count_limit = clim;
      csr_index <= CSR_MEAN_LIMIT;
      csr_wdata <= {1'b0, mlim};
      @(posedge clock);
      cfg_mean_limit = mlim;
      csr_we <= 1'b0;
   endtask

   task automatic send_row(input int len, input int style);
      int i;
      for (i = 0; i < len; i++) begin
         send_pixel(make_pixel(style), i == len - 1);
      end
   endtask

   // Rows of different lengths under the reset limits, masked and clean.
   task automatic test_row_replay();
      send_pixel(16'sd32767, 1'b0);
      send_pixel(-16'sd32768, 1'b0);
      send_pixel(16'sd0, 1'b0);
      send_pixel(16'sd11, 1'b0);
      send_pixel(16'sd10, 1'b1);
      send_pixel(16'sd300, 1'b0);
      send_pixel(16'sd300, 1'b0);
      send_pixel(16'sd401, 1'b0);
      send_pixel(-16'sd5, 1'b0);
      send_pixel(-16'sd1000, 1'b0);
      send_pixel(16'sd300, 1'b1);
      send_pixel(16'sd5, 1'b1);
      send_pixel(16'sd500, 1'b0);
      send_pixel(16'sd500, 1'b0);
      send_pixel(16'sd500, 1'b1);
      send_pixel(16'sd1, 1'b1);
   endtask

   // Count limit and mean limit right at and just past their boundaries.
   task automatic test_mask_limits();
      set_limits(16'sd10, 13'd2, 15'd32767);
      send_pixel(16'sd11, 1'b0);
      send_pixel(16'sd12, 1'b0);
      send_pixel(16'sd13, 1'b1);
      send_pixel(16'sd11, 1'b0);
      send_pixel(16'sd12, 1'b1);
      set_limits(16'sd10, 13'd4096, 15'd20);
      send_pixel(16'sd20, 1'b0);
      send_pixel(16'sd21, 1'b0);
      send_pixel(16'sd0, 1'b1);
      send_pixel(16'sd21, 1'b0);
      send_pixel(16'sd19, 1'b1);
      set_limits(16'sd10, 13'd0, 15'd0);
      send_pixel(16'sd11, 1'b1);
   endtask

   // Rows of extreme and of random pixels under both extreme thresholds and high
   // limits, each of a different length from the row before it.
   task automatic test_long_rows();
      int i;
      set_limits(-16'sd32768, 13'd4096, 15'd32767);
      for (i = 0; i < 40; i++) begin
         send_pixel(16'sd32767, i == 39);
      end
      for (i = 0; i < 30; i++) begin
         send_pixel(($urandom_range(0, 9) == 0) ? -16'sd32768 : -16'sd32767, i == 29);
      end
      set_limits(16'sd32767, 13'd4096, 15'd32767);
      send_row(50, 0);
      send_row(1, 0);
   endtask

   task automatic test_random_rows();
      int phase, sent, len, style, i, r;
      bit paused;
      logic signed [THR_BITS-1:0] thr;
      logic [CLIM_BITS-1:0]       clim;
      logic [MLIM_BITS-1:0]       mlim;
      paused = 0;
      for (phase = 0; phase < 6; phase++) begin
         send_calm = (phase == 2);
         recv_calm = (phase == 4);
         r    = $urandom_range(0, 9);
         thr  = (r == 0) ? -16'sd32768 : (r == 1) ? 16'sd32767 :
                (r == 6) ? THR_BITS'($urandom()) : THR_BITS'(int'($urandom_range(0, 400)) - 200);
         clim = (r == 2) ? 13'd0 : (r == 3) ? 13'd4096 : CLIM_BITS'($urandom_range(0, 20));
         mlim = (r == 4) ? 15'd0 : (r == 5) ? 15'd32767 : MLIM_BITS'($urandom_range(0, 1500));
         set_limits(thr, clim, mlim);
         sent = 0;
         while (sent < 50) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
            style = $urandom_range(0, 3);
            for (i = 0; i < len; i++) begin
               if (i == len / 2 && (!paused || $urandom_range(0, 19) == 0)) begin
                  wait_drained();
                  paused = 1;
               end
               send_pixel(make_pixel(style), i == len - 1);
            end
            sent += len;
         end
      end
      send_calm = 0;
      recv_calm = 0;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_beats.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            failures++;
         end else begin
            beat_due = due_beats.pop_front();
            check_field("out_valid", beat_due.out_valid, rsp_out_valid);
            check_field("out_pixel", $signed(beat_due.out_pixel), rsp_out_pixel);
            check_field("out_row_end", beat_due.out_row_end, rsp_out_row_end);
            check_field("row_charge_sum", $signed(beat_due.charge_sum), rsp_row_charge_sum);
            check_field("row_count_above", beat_due.count_above, rsp_row_count_above);
            check_field("row_masked", beat_due.masked, rsp_row_masked);
            check_field("row_first_pixel", $signed(beat_due.first_pixel), rsp_row_first_pixel);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("FAIL row_noise_mask");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(recv_calm);
      end
   end

   initial begin
      clear_row_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_row_replay();
      test_mask_limits();
      test_long_rows();
      test_random_rows();
      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("PASS row_noise_mask");
      end else begin
         $display("FAIL row_noise_mask");
      end
      $finish;
   end

endmodule
